[rtl/core/lbh_pkg.sv]
package lbh_pkg;

  localparam int SEC_W       = 32;
  localparam int USEC_W      = 32;
  localparam int MUL_W       = 20;
  localparam int TS_W        = 64;
  localparam int BUCKET_W    = 11;
  localparam int NUM_BUCKETS = 2048;
  localparam int EXP_W       = 6;
  localparam int FRAC_W      = 5;
  localparam int NUM_FRAC    = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int COUNT_OUT_W = 32;
  localparam int NUM_HIST    = 3;
  localparam int SEL_W       = 2;
  localparam int SHIFT_W     = 2 * TS_W - 1;

  localparam logic [SEC_W-1:0] SEC_MISSING  = '1;
  localparam logic [MUL_W-1:0] USEC_PER_SEC = 20'd1000000;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [SEL_W-1:0] HIST_FIRST_GAP = 2'd0;
  localparam logic [SEL_W-1:0] HIST_TRANSFER  = 2'd1;
  localparam logic [SEL_W-1:0] HIST_OVERALL   = 2'd2;

  typedef struct packed {
    logic                func;
    logic [SEC_W-1:0]    start_sec;
    logic [USEC_W-1:0]   start_usec;
    logic [SEC_W-1:0]    first_sec;
    logic [USEC_W-1:0]   first_usec;
    logic [SEC_W-1:0]    last_sec;
    logic [USEC_W-1:0]   last_usec;
    logic [SEL_W-1:0]    hist_select;
    logic [BUCKET_W-1:0] read_bucket;
  } in_item_t;

  typedef struct packed {
    logic                   recorded;
    logic [BUCKET_W-1:0]    bucket_first_gap;
    logic [BUCKET_W-1:0]    bucket_transfer;
    logic [BUCKET_W-1:0]    bucket_overall;
    logic [COUNT_OUT_W-1:0] count_value;
  } res_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_DIFF,
    ST_SEARCH,
    ST_FETCH,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                load_item;
    logic                calc_ts;
    logic                calc_diff;
    logic                search_init;
    logic                search_step;
    logic [BUCKET_W-1:0] step_mask;
    logic                mem_rd;
    logic                mem_wr;
    logic                clr_wr;
    logic [BUCKET_W-1:0] clr_addr;
    logic                out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic missing;
  } ctrl_status_t;

  typedef logic [TS_W:0] thr_t;
  typedef thr_t thr_tab_t [NUM_FRAC];

  // First fraction bits of log2 of a Q1.63 mantissa, by truncated repeated squaring.
  function automatic logic [FRAC_W-1:0] frac_code(logic [TS_W-1:0] m);
    logic [2*TS_W-1:0]   p;
    logic [TS_W-1:0]     mm;
    logic [FRAC_W-1:0]   code;
    mm   = m;
    code = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      p = {{TS_W{1'b0}}, mm} * {{TS_W{1'b0}}, mm};
      if (p[2*TS_W-1]) begin
        mm   = p[2*TS_W-1:TS_W];
        code = {code[FRAC_W-2:0], 1'b1};
      end else begin
        mm   = p[2*TS_W-2:TS_W-1];
        code = {code[FRAC_W-2:0], 1'b0};
      end
    end
    return code;
  endfunction

  // Smallest mantissa reaching each fraction code; 2^64 marks a code that is never reached.
  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    thr_t     lo;
    thr_t     hi;
    thr_t     mid;
    for (int k = 0; k < NUM_FRAC; k++) begin
      lo = thr_t'(1) << (TS_W - 1);
      hi = thr_t'(1) << TS_W;
      if (k == 0) begin
        hi = lo;
      end else begin
        while (hi - lo > thr_t'(1)) begin
          mid = lo + ((hi - lo) >> 1);
          if (frac_code(mid[TS_W-1:0]) >= FRAC_W'(k)) begin
            hi = mid;
          end else begin
            lo = mid;
          end
        end
      end
      tab[k] = hi;
    end
    return tab;
  endfunction

  localparam thr_tab_t FRAC_THR = build_thr();

endpackage

[rtl/core/lbh_channels.sv]
interface lbh_item_if;
  logic               valid;
  logic               ready;
  lbh_pkg::in_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lbh_res_if;
  logic               valid;
  logic               ready;
  lbh_pkg::res_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/lbh_search.sv]
module lbh_search (
  input  logic                         clk,
  input  logic [lbh_pkg::TS_W-1:0]     diff,
  input  logic                         init,
  input  logic                         step,
  input  logic [lbh_pkg::BUCKET_W-1:0] step_mask,
  output logic [lbh_pkg::BUCKET_W-1:0] bucket
);

  logic [lbh_pkg::BUCKET_W-1:0] cand;
  logic [lbh_pkg::EXP_W-1:0]    cand_exp;
  logic [lbh_pkg::FRAC_W-1:0]   cand_frac;
  logic [lbh_pkg::SHIFT_W-1:0]  diff_sh;
  lbh_pkg::thr_t                thr;
  logic                         reach;

  // A candidate bucket splits into an octave and a fraction code. The gap reaches it
  // when the gap, scaled to that octave, is at or above the fraction threshold.
  always_comb begin
    cand      = bucket | step_mask;
    cand_exp  = cand[lbh_pkg::BUCKET_W-1:lbh_pkg::FRAC_W];
    cand_frac = cand[lbh_pkg::FRAC_W-1:0];
    diff_sh   = {{(lbh_pkg::SHIFT_W - lbh_pkg::TS_W){1'b0}}, diff}
                << (lbh_pkg::EXP_W'(lbh_pkg::TS_W - 1) - cand_exp);
    thr       = lbh_pkg::FRAC_THR[cand_frac];
    reach     = diff_sh >= {{(lbh_pkg::SHIFT_W - lbh_pkg::TS_W - 1){1'b0}}, thr};
  end

  always_ff @(posedge clk) begin
    if (init) begin
      bucket <= '0;
    end else if (step && reach) begin
      bucket <= cand;
    end
  end

endmodule

[rtl/core/lbh_ctrl.sv]
module lbh_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  input  lbh_pkg::ctrl_status_t status,
  output lbh_pkg::ctrl_cmd_t    cmd
);

  lbh_pkg::state_t              state;
  lbh_pkg::state_t              state_next;
  logic [lbh_pkg::BUCKET_W-1:0] clr_addr;
  logic [lbh_pkg::BUCKET_W-1:0] step_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lbh_pkg::ST_CLEAR;
      clr_addr  <= '0;
      step_mask <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.search_init) begin
        step_mask <= {1'b1, {(lbh_pkg::BUCKET_W - 1){1'b0}}};
      end else if (cmd.search_step) begin
        step_mask <= step_mask >> 1;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.clr_addr  = clr_addr;
    cmd.step_mask = step_mask;
    item_ready    = 1'b0;
    unique case (state)
      lbh_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (&clr_addr) begin
          state_next = lbh_pkg::ST_IDLE;
        end
      end
      lbh_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = lbh_pkg::ST_CONV;
        end
      end
      lbh_pkg::ST_CONV: begin
        cmd.calc_ts = 1'b1;
        priority if (status.is_read) begin
          state_next = lbh_pkg::ST_FETCH;
        end else if (status.missing) begin
          state_next = lbh_pkg::ST_DONE;
        end else begin
          state_next = lbh_pkg::ST_DIFF;
        end
      end
      lbh_pkg::ST_DIFF: begin
        cmd.calc_diff   = 1'b1;
        cmd.search_init = 1'b1;
        state_next      = lbh_pkg::ST_SEARCH;
      end
      lbh_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (step_mask[0]) begin
          state_next = lbh_pkg::ST_FETCH;
        end
      end
      lbh_pkg::ST_FETCH: begin
        cmd.mem_rd = 1'b1;
        state_next = status.is_read ? lbh_pkg::ST_DONE : lbh_pkg::ST_UPDATE;
      end
      lbh_pkg::ST_UPDATE: begin
        cmd.mem_wr = 1'b1;
        state_next = lbh_pkg::ST_DONE;
      end
      lbh_pkg::ST_DONE: begin
        if (!res_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = lbh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbh_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/core/lbh_datapath.sv]
module lbh_datapath (
  input  logic                  clk,
  input  lbh_pkg::in_item_t     item_data,
  input  lbh_pkg::ctrl_cmd_t    cmd,
  output lbh_pkg::ctrl_status_t status,
  output lbh_pkg::res_item_t    res_data
);

  lbh_pkg::in_item_t               item_q;
  logic [lbh_pkg::TS_W-1:0]        ts       [lbh_pkg::NUM_HIST];
  logic [lbh_pkg::TS_W-1:0]        diff     [lbh_pkg::NUM_HIST];
  logic [lbh_pkg::BUCKET_W-1:0]    bucket   [lbh_pkg::NUM_HIST];
  logic [lbh_pkg::COUNT_WIDTH-1:0] rd_data  [lbh_pkg::NUM_HIST];
  logic [lbh_pkg::COUNT_WIDTH-1:0] rd_count;
  logic                            recorded;

  function automatic logic [lbh_pkg::TS_W-1:0] to_usec(
    logic [lbh_pkg::SEC_W-1:0]  sec,
    logic [lbh_pkg::USEC_W-1:0] usec
  );
    logic [lbh_pkg::SEC_W+lbh_pkg::MUL_W-1:0] prod;
    prod = sec * lbh_pkg::USEC_PER_SEC;
    return lbh_pkg::TS_W'(prod) + lbh_pkg::TS_W'(usec);
  endfunction

  assign status.is_read = (item_q.func == lbh_pkg::FUNC_READ);
  assign status.missing = (item_q.start_sec == lbh_pkg::SEC_MISSING)
                       || (item_q.first_sec == lbh_pkg::SEC_MISSING)
                       || (item_q.last_sec  == lbh_pkg::SEC_MISSING);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item_data;
    end
    if (cmd.calc_ts) begin
      ts[0] <= to_usec(item_q.start_sec, item_q.start_usec);
      ts[1] <= to_usec(item_q.first_sec, item_q.first_usec);
      ts[2] <= to_usec(item_q.last_sec,  item_q.last_usec);
    end
    // Gaps wrap modulo 2^64, so a negative gap lands in a high bucket.
    if (cmd.calc_diff) begin
      diff[0] <= ts[1] - ts[0];
      diff[1] <= ts[2] - ts[1];
      diff[2] <= ts[2] - ts[0];
    end
  end

  for (genvar h = 0; h < lbh_pkg::NUM_HIST; h++) begin : g_hist
    logic [lbh_pkg::COUNT_WIDTH-1:0] mem [lbh_pkg::NUM_BUCKETS];
    logic [lbh_pkg::BUCKET_W-1:0]    rd_addr;
    logic [lbh_pkg::BUCKET_W-1:0]    wr_addr;
    logic [lbh_pkg::COUNT_WIDTH-1:0] wr_data;
    logic                            wr_en;

    lbh_search u_search (
      .clk       (clk),
      .diff      (diff[h]),
      .init      (cmd.search_init),
      .step      (cmd.search_step),
      .step_mask (cmd.step_mask),
      .bucket    (bucket[h])
    );

    always_comb begin
      rd_addr = status.is_read ? item_q.read_bucket : bucket[h];
      wr_en   = cmd.mem_wr || cmd.clr_wr;
      wr_addr = cmd.clr_wr ? cmd.clr_addr : bucket[h];
      if (cmd.clr_wr) begin
        wr_data = '0;
      end else if (&rd_data[h]) begin
        wr_data = rd_data[h];
      end else begin
        wr_data = rd_data[h] + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.mem_rd) begin
        rd_data[h] <= mem[rd_addr];
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
    end
  end

  always_comb begin
    recorded = !status.is_read && !status.missing;
    rd_count = '0;
    if (status.is_read) begin
      unique case (item_q.hist_select)
        lbh_pkg::HIST_FIRST_GAP: rd_count = rd_data[0];
        lbh_pkg::HIST_TRANSFER:  rd_count = rd_data[1];
        lbh_pkg::HIST_OVERALL:   rd_count = rd_data[2];
        default:                 rd_count = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_data.recorded         <= recorded;
      res_data.bucket_first_gap <= recorded ? bucket[0] : '0;
      res_data.bucket_transfer  <= recorded ? bucket[1] : '0;
      res_data.bucket_overall   <= recorded ? bucket[2] : '0;
      res_data.count_value      <= lbh_pkg::COUNT_OUT_W'(rd_count);
    end
  end

endmodule

[rtl/core/log_bucket_latency_histogram_unit.sv]
// Latency histogram with logarithmic buckets, three histograms of 2048 counters.
// The item channel takes a request: func 0 records three timestamps, func 1 reads
// one counter chosen by hist_select and read_bucket. Every request gives exactly
// one result on the result channel.
// A record request converts the timestamps to microseconds, forms the three wrapped
// gaps and finds each bucket by an 11-step binary search over the octave/fraction
// thresholds, one step per cycle for all three gaps at once. A read-modify-write of
// the three counter memories follows. A read request skips the search and fetches
// one counter; a skipped record request goes straight to its result.
// One request is in flight at a time: a new one is taken only once the last result
// has been loaded into the output register.
// After reset the block clears all counters, one address per cycle in all three
// memories; ready stays low during that pass.
// The result sits in an output register. A new request is accepted while that
// result waits; if the receiver stalls, the next result holds in its last state
// until the register frees up.
module log_bucket_latency_histogram_unit (
  input  logic             clk,
  input  logic             rst,
  lbh_item_if.sink         item,
  lbh_res_if.source        result
);

  lbh_pkg::ctrl_cmd_t    cmd;
  lbh_pkg::ctrl_status_t status;

  lbh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .status     (status),
    .cmd        (cmd)
  );

  lbh_datapath u_datapath (
    .clk       (clk),
    .item_data (item.data),
    .cmd       (cmd),
    .status    (status),
    .res_data  (result.data)
  );

endmodule

[rtl/core/lbh_checker.sv]
module lbh_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               res_valid,
  input logic               res_ready,
  input lbh_pkg::res_item_t res_data
);

  // The clearing pass keeps the block closed right after reset.
  a_closed_after_reset: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("item ready right after reset");

  // Only one request is taken at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item ready again right after a request");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.recorded |->
      res_data.bucket_first_gap == '0 && res_data.bucket_transfer == '0 &&
      res_data.bucket_overall == '0)
    else $error("bucket reported for an item that was not recorded");

  a_record_no_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.recorded |-> res_data.count_value == '0)
    else $error("count reported for a recorded item");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

endmodule

bind log_bucket_latency_histogram_unit lbh_checker u_lbh_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.data)
);

[tb/lbh_hist_checker.sv]
module lbh_hist_checker (
  input  logic clk,
  input  logic rst,
  lbh_item_if  item,
  lbh_res_if   result,
  output int   fail_count,
  output int   pending,
  output int   n_recorded,
  output int   n_skipped,
  output int   n_reads
);

  logic [lbh_pkg::COUNT_WIDTH-1:0] tally [lbh_pkg::NUM_HIST][lbh_pkg::NUM_BUCKETS];
  lbh_pkg::res_item_t              due_results [$];

  function automatic logic [lbh_pkg::TS_W-1:0] to_usec(logic [lbh_pkg::SEC_W-1:0] s,
                                                       logic [lbh_pkg::USEC_W-1:0] u);
    return {32'b0, s} * 64'd1000000 + {32'b0, u};
  endfunction

  // log2 in fixed point: octave from the top set bit, then 24 fraction bits by
  // squaring the normalized mantissa and keeping it in [1,2).
  function automatic logic [lbh_pkg::BUCKET_W-1:0] log_bucket(logic [lbh_pkg::TS_W-1:0] d);
    logic [lbh_pkg::TS_W-1:0]   m;
    logic [2*lbh_pkg::TS_W-1:0] sq;
    logic [23:0]                frac;
    logic [63:0]                lg;
    logic [63:0]                b;
    int                         e;
    if (d == '0) begin
      return '0;
    end
    e = 63;
    while (e > 0 && !d[e]) begin
      e--;
    end
    m    = d << (63 - e);
    frac = '0;
    for (int i = 0; i < 24; i++) begin
      sq = {64'b0, m} * {64'b0, m};
      if (sq[2*lbh_pkg::TS_W-1]) begin
        m    = sq[2*lbh_pkg::TS_W-1:lbh_pkg::TS_W];
        frac = {frac[22:0], 1'b1};
      end else begin
        m    = sq[2*lbh_pkg::TS_W-2:lbh_pkg::TS_W-1];
        frac = {frac[22:0], 1'b0};
      end
    end
    lg = (64'(e) << 24) | 64'(frac);
    b  = (lg * 64'(lbh_pkg::NUM_BUCKETS)) >> 30;
    if (b > 64'(lbh_pkg::NUM_BUCKETS - 1)) begin
      b = 64'(lbh_pkg::NUM_BUCKETS - 1);
    end
    return b[lbh_pkg::BUCKET_W-1:0];
  endfunction

  function automatic void bump(int h, logic [lbh_pkg::BUCKET_W-1:0] b);
    if (tally[h][b] != '1) begin
      tally[h][b] = tally[h][b] + 1'b1;
    end
  endfunction

  function automatic lbh_pkg::res_item_t predict_result(lbh_pkg::in_item_t r);
    lbh_pkg::res_item_t       y;
    logic [lbh_pkg::TS_W-1:0] ts;
    logic [lbh_pkg::TS_W-1:0] tf;
    logic [lbh_pkg::TS_W-1:0] tl;
    y = '0;
    if (r.func == lbh_pkg::FUNC_READ) begin
      if (r.read_bucket < lbh_pkg::NUM_BUCKETS && r.hist_select <= lbh_pkg::HIST_OVERALL) begin
        y.count_value = lbh_pkg::COUNT_OUT_W'(tally[r.hist_select][r.read_bucket]);
      end
    end else if (r.start_sec != lbh_pkg::SEC_MISSING && r.first_sec != lbh_pkg::SEC_MISSING &&
                 r.last_sec != lbh_pkg::SEC_MISSING) begin
      ts = to_usec(r.start_sec, r.start_usec);
      tf = to_usec(r.first_sec, r.first_usec);
      tl = to_usec(r.last_sec, r.last_usec);
      y.recorded         = 1'b1;
      y.bucket_first_gap = log_bucket(tf - ts);
      y.bucket_transfer  = log_bucket(tl - tf);
      y.bucket_overall   = log_bucket(tl - ts);
      bump(lbh_pkg::HIST_FIRST_GAP, y.bucket_first_gap);
      bump(lbh_pkg::HIST_TRANSFER, y.bucket_transfer);
      bump(lbh_pkg::HIST_OVERALL, y.bucket_overall);
    end
    return y;
  endfunction

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch in %s: expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
      fail_count++;
    end
  endtask

  task automatic check_result(lbh_pkg::res_item_t got);
    lbh_pkg::res_item_t want;
    if (due_results.size() == 0) begin
      $display("%0t unexpected result: expected none, got 0x%0h", $time, got);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      field_check("recorded", 32'(want.recorded), 32'(got.recorded));
      field_check("bucket_first_gap", 32'(want.bucket_first_gap), 32'(got.bucket_first_gap));
      field_check("bucket_transfer", 32'(want.bucket_transfer), 32'(got.bucket_transfer));
      field_check("bucket_overall", 32'(want.bucket_overall), 32'(got.bucket_overall));
      field_check("count_value", want.count_value, got.count_value);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    n_recorded = 0;
    n_skipped  = 0;
    n_reads    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int h = 0; h < lbh_pkg::NUM_HIST; h++) begin
        for (int b = 0; b < lbh_pkg::NUM_BUCKETS; b++) begin
          tally[h][b] = '0;
        end
      end
      due_results.delete();
    end else begin
      // The result of an earlier request leaves before the new one is queued.
      if (result.valid && result.ready) begin
        check_result(result.data);
      end
      if (item.valid && item.ready) begin
        due_results.push_back(predict_result(item.data));
        if (item.data.func == lbh_pkg::FUNC_READ) begin
          n_reads++;
        end else if (due_results[$].recorded) begin
          n_recorded++;
        end else begin
          n_skipped++;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam logic [lbh_pkg::SEL_W-1:0] HIST_NONE = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  lbh_item_if item_ch ();
  lbh_res_if  result_ch ();

  int fail_count;
  int pending;
  int n_recorded;
  int n_skipped;
  int n_reads;

  bit pace_idle;
  bit hold_rx;
  logic [lbh_pkg::BUCKET_W-1:0] seen_buckets [$];

  log_bucket_latency_histogram_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  lbh_hist_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .n_recorded (n_recorded),
    .n_skipped  (n_skipped),
    .n_reads    (n_reads)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic lbh_pkg::in_item_t mk_rec(logic [31:0] ss, logic [31:0] su,
                                               logic [31:0] fs, logic [31:0] fu,
                                               logic [31:0] ls, logic [31:0] lu);
    lbh_pkg::in_item_t r;
    r            = '0;
    r.func       = lbh_pkg::FUNC_RECORD;
    r.start_sec  = ss;
    r.start_usec = su;
    r.first_sec  = fs;
    r.first_usec = fu;
    r.last_sec   = ls;
    r.last_usec  = lu;
    return r;
  endfunction

  function automatic lbh_pkg::in_item_t mk_read(logic [lbh_pkg::SEL_W-1:0] sel,
                                                logic [lbh_pkg::BUCKET_W-1:0] b);
    lbh_pkg::in_item_t r;
    r             = '0;
    r.func        = lbh_pkg::FUNC_READ;
    r.hist_select = sel;
    r.read_bucket = b;
    return r;
  endfunction

  // Latency in microseconds: mostly spread over many octaves, with a few
  // recurring values so that some counters climb.
  function automatic logic [63:0] lat_delta();
    logic [63:0] d;
    int          w;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: d = 64'd1500;
      1: d = 64'd40000;
      2: d = 64'd250000;
      3: d = 64'd0;
      4: ;
      default: begin
        w = $urandom_range(0, 48);
        d = d & ((64'd1 << w) - 64'd1);
      end
    endcase
    return d;
  endfunction

  function automatic void stamp_after(input logic [31:0] bsec, input logic [31:0] busec,
                                      input logic [63:0] delta, output logic [31:0] osec,
                                      output logic [31:0] ousec);
    logic [63:0] tot;
    tot   = {32'b0, busec} + (delta % 64'd1000000);
    osec  = bsec + 32'(delta / 64'd1000000) + 32'(tot / 64'd1000000);
    ousec = 32'(tot % 64'd1000000);
  endfunction

  function automatic lbh_pkg::in_item_t rand_req();
    lbh_pkg::in_item_t r;
    logic [223:0]      rnd;
    logic [31:0]       tsec;
    logic [31:0]       tusec;
    logic [2:0]        miss;
    int                pick;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = rnd[$bits(lbh_pkg::in_item_t)-1:0];
    r.func = lbh_pkg::FUNC_RECORD;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      r.func = lbh_pkg::FUNC_READ;
      if (pick < 16 && seen_buckets.size() > 0) begin
        r.read_bucket = seen_buckets[$urandom_range(0, seen_buckets.size() - 1)];
        r.hist_select = lbh_pkg::SEL_W'($urandom_range(lbh_pkg::HIST_FIRST_GAP,
                                                       lbh_pkg::HIST_OVERALL));
      end
    end else if (pick >= 32) begin
      r.start_usec = $urandom_range(0, 999999);
      stamp_after(r.start_sec, r.start_usec, lat_delta(), r.first_sec, r.first_usec);
      stamp_after(r.first_sec, r.first_usec, lat_delta(), r.last_sec, r.last_usec);
      // Out-of-order stamps give wrapped, negative gaps.
      if (pick < 38) begin
        tsec = r.start_sec;  tusec = r.start_usec;
        r.start_sec = r.first_sec;  r.start_usec = r.first_usec;
        r.first_sec = tsec;  r.first_usec = tusec;
      end else if (pick < 42) begin
        tsec = r.last_sec;  tusec = r.last_usec;
        r.last_sec = r.first_sec;  r.last_usec = r.first_usec;
        r.first_sec = tsec;  r.first_usec = tusec;
      end
      if (pick >= 92) begin
        miss = 3'($urandom_range(1, 7));
        if (miss[0]) r.start_sec = lbh_pkg::SEC_MISSING;
        if (miss[1]) r.first_sec = lbh_pkg::SEC_MISSING;
        if (miss[2]) r.last_sec = lbh_pkg::SEC_MISSING;
      end
    end
    return r;
  endfunction

  task automatic send_req(lbh_pkg::in_item_t r);
    int gap;
    gap = pace_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.data  <= r;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Result side: random stalls per result, and one long hold-off on request.
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) begin
      @(negedge clk);
    end
    forever begin
      gap = pace_idle ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      if (result_ch.data.recorded) begin
        seen_buckets.push_back(result_ch.data.bucket_first_gap);
        seen_buckets.push_back(result_ch.data.bucket_transfer);
        seen_buckets.push_back(result_ch.data.bucket_overall);
        while (seen_buckets.size() > 48) begin
          void'(seen_buckets.pop_front());
        end
      end
      if (hold_rx) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
    end
  end

  initial begin
    lbh_pkg::in_item_t directed [$];
    lbh_pkg::in_item_t r;
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    pace_idle     = 1'b1;
    hold_rx       = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    directed.push_back(mk_read(lbh_pkg::HIST_FIRST_GAP, '0));
    directed.push_back(mk_rec('0, '0, '0, '0, '0, '0));
    directed.push_back(mk_rec(0, 0, 0, 1, 0, 2));
    // A gap of minus one wraps to the largest 64-bit value, the top bucket.
    directed.push_back(mk_rec(0, 1, 0, 0, 0, 0));
    directed.push_back(mk_rec(32'hFFFF_FFFE, '1, 0, 0, 32'hFFFF_FFFE, 999999));
    directed.push_back(mk_rec(5, '1, 6, '1, 7, '1));
    directed.push_back(mk_rec(lbh_pkg::SEC_MISSING, 0, 3, 0, 4, 0));
    directed.push_back(mk_rec(1, 0, lbh_pkg::SEC_MISSING, 0, 4, 0));
    directed.push_back(mk_rec(1, 0, 3, 0, lbh_pkg::SEC_MISSING, '1));
    directed.push_back(mk_rec(lbh_pkg::SEC_MISSING, '1, lbh_pkg::SEC_MISSING, '1,
                              lbh_pkg::SEC_MISSING, '1));
    directed.push_back(mk_rec(1000, 500000, 1000, 900000, 1000, 700000));
    r = mk_rec(0, 0, 0, 0, 0, 0);
    r.hist_select = HIST_NONE;
    r.read_bucket = '1;
    directed.push_back(r);
    directed.push_back(mk_read(lbh_pkg::HIST_FIRST_GAP, '0));
    directed.push_back(mk_read(lbh_pkg::HIST_TRANSFER, '0));
    directed.push_back(mk_read(lbh_pkg::HIST_OVERALL, '0));
    directed.push_back(mk_read(lbh_pkg::HIST_OVERALL, '1));
    directed.push_back(mk_read(lbh_pkg::HIST_FIRST_GAP, '1));
    directed.push_back(mk_read(HIST_NONE, '0));
    directed.push_back(mk_read(HIST_NONE, '1));
    r = mk_read(lbh_pkg::HIST_TRANSFER, '1);
    r.start_sec  = '1;  r.start_usec = '1;
    r.first_sec  = '1;  r.first_usec = '1;
    r.last_sec   = '1;  r.last_usec  = '1;
    directed.push_back(r);
    foreach (directed[i]) begin
      send_req(directed[i]);
    end
    drain();

    // Random phases; phases 0 and 3 run without idle cycles on either side.
    for (int ph = 0; ph < 5; ph++) begin
      pace_idle = (ph != 0 && ph != 3);
      for (int k = 0; k < 306; k++) begin
        if (ph == 2 && k == 60) begin
          hold_rx = 1'b1;
        end
        send_req(rand_req());
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d requests: %0d recorded, %0d skipped records, %0d counter reads.",
             n_recorded + n_skipped + n_reads, n_recorded, n_skipped, n_reads);
    $display("Included a %0d-cycle result stall and drained pauses between phases.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
